FILE: rtl/sfd_pkg.sv
// Shared types and constants of the stereo feedback delay unit.
package sfd_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int LEN_REG_W  = 17;
   localparam int GAIN_REG_W = 16;
   localparam int CSR_DATA_W = 17;
   localparam int CSR_IDX_W  = 1;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DELAY_LENGTH  = 1'b0,
      CSR_FEEDBACK_GAIN = 1'b1
   } csr_index_type;

   // Per-cycle control handed from the top level to each channel lane.
   typedef struct packed {
      logic rd_en;     // a word is accepted: read the ring at the pointer
      logic wr_en;     // the word in the update stage writes its new entry
      logic clearing;  // ring clearing pass after reset, writes zeros
      logic bypass;    // the update stage's entry was written as it was read
   } lane_ctl_type;

endpackage

FILE: rtl/sfd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module sfd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // A read and a write of the same entry in one cycle return the old data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/sfd_lane.sv
// One channel lane: delay ring, write bypass and the feedback update datapath.
module sfd_lane #(
   parameter int DEPTH     = 65536,
   parameter int GAIN_W    = 16,
   parameter int FRAC_BITS = 15
) (
   input  logic                                 clock,
   input  sfd_pkg::lane_ctl_type                ctl,
   input  logic [$clog2(DEPTH)-1:0]             rd_addr,
   input  logic [$clog2(DEPTH)-1:0]             wr_addr,
   input  logic [GAIN_W-1:0]                    gain,
   input  logic signed [sfd_pkg::SAMPLE_W-1:0]  in_sample,
   output logic signed [sfd_pkg::SAMPLE_W-1:0]  old_sample
);

   localparam int SW     = sfd_pkg::SAMPLE_W;
   localparam int PROD_W = SW + GAIN_W;

   logic signed [SW-1:0] hold_sample_ff, hold_sample_in;
   logic signed [SW-1:0] last_wr_ff, last_wr_in;
   logic [SW-1:0]        ram_rd_data;
   logic [SW-1:0]        ram_wr_data;
   logic                 ram_wr_en;
   logic signed [SW-1:0] old_val;
   logic [SW-1:0]        mag;
   logic [PROD_W-1:0]    prod;
   logic [SW:0]          term_mag;
   logic signed [SW+1:0] term;
   logic signed [SW+1:0] sum;
   logic signed [SW-1:0] upd;

   sfd_ram #(
      .WIDTH(SW),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ctl.rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      hold_sample_in = ctl.rd_en ? in_sample : hold_sample_ff;
      old_val = ctl.bypass ? last_wr_ff : $signed(ram_rd_data);
      // Magnitude of the stored value; the most negative sample fits unsigned.
      mag = old_val[SW-1] ? (~old_val + SW'(1)) : old_val;
      prod = PROD_W'(mag) * PROD_W'(gain);
      term_mag = (SW+1)'(prod >> FRAC_BITS);
      term = old_val[SW-1] ? -$signed({1'b0, term_mag}) : $signed({1'b0, term_mag});
      sum = $signed({{2{hold_sample_ff[SW-1]}}, hold_sample_ff}) + term;
      if (sum > $signed((SW+2)'(2**(SW-1) - 1))) begin
         upd = {1'b0, {(SW-1){1'b1}}};
      end else if (sum < -$signed((SW+2)'(2**(SW-1)))) begin
         upd = {1'b1, {(SW-1){1'b0}}};
      end else begin
         upd = sum[SW-1:0];
      end
      last_wr_in  = ctl.wr_en ? upd : last_wr_ff;
      ram_wr_en   = ctl.clearing || ctl.wr_en;
      ram_wr_data = ctl.clearing ? '0 : upd;
   end

   always_ff @(posedge clock) begin
      hold_sample_ff <= hold_sample_in;
      last_wr_ff     <= last_wr_in;
   end

   assign old_sample = old_val;

endmodule

FILE: rtl/stereo_feedback_delay_unit.sv
// Top level of the stereo feedback delay unit: control, pointer and result stage.
//
// Stereo echo with feedback. Each accepted word is one stereo frame; the block
// returns the sample stored in each channel's delay ring at the shared pointer
// and writes back input plus the stored sample times the feedback gain
// (product truncated toward zero, sum saturated to 16 bits). The pointer wraps
// at the configured delay length, which is clamped to 1..RING_DEPTH, and a
// gain above unity acts as unity. One word is accepted per clock cycle when
// the result side keeps up. A word's ring read is issued in the cycle it is
// accepted; the update is written when the word leaves the update stage, in
// the same cycle its result lands in the output register that drives
// rsp_valid. The gap between read and write of the single ring memory port
// pair is covered by a bypass register, so a delay length of one still runs
// at full rate. After reset the rings are cleared one entry per cycle;
// req_ready stays low during that pass, while configuration writes are taken
// at any time.
module stereo_feedback_delay_unit #(
   parameter int RING_DEPTH         = 65536,
   parameter int GAIN_FRACTION_BITS = 15
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [sfd_pkg::SAMPLE_W-1:0]     req_left_in,
   input  logic signed [sfd_pkg::SAMPLE_W-1:0]     req_right_in,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [sfd_pkg::SAMPLE_W-1:0]     rsp_left_out,
   output logic signed [sfd_pkg::SAMPLE_W-1:0]     rsp_right_out,
   input  logic                                    csr_wr_en,
   input  logic [sfd_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [sfd_pkg::CSR_DATA_W-1:0]          csr_wdata
);

   localparam int SW    = sfd_pkg::SAMPLE_W;
   localparam int AW    = $clog2(RING_DEPTH);
   // Length comparisons need room for the register value and the ring depth.
   localparam int CMP_W = (AW + 1 > sfd_pkg::LEN_REG_W) ? AW + 1 : sfd_pkg::LEN_REG_W;
   // Gain width must hold unity, which may exceed the 16-bit register.
   localparam int GW    = (GAIN_FRACTION_BITS + 1 > sfd_pkg::GAIN_REG_W) ?
                          GAIN_FRACTION_BITS + 1 : sfd_pkg::GAIN_REG_W;

   // Configuration, stored already clamped to the effective values.
   logic [CMP_W-1:0] len_eff_ff, len_eff_in;
   logic [GW-1:0]    gain_eff_ff, gain_eff_in;
   logic [CMP_W-1:0] len_raw;
   logic [GW-1:0]    gain_raw;
   logic [GW-1:0]    gain_unity;

   // Clearing pass.
   logic             clr_active_ff, clr_active_in;
   logic [AW-1:0]    clr_cnt_ff, clr_cnt_in;

   // Pointer and update stage.
   logic [AW-1:0]    ptr_ff, ptr_in;
   logic [CMP_W-1:0] ptr_plus;
   logic             s1_valid_ff, s1_valid_in;
   logic [AW-1:0]    s1_addr_ff, s1_addr_in;
   logic             hit_ff, hit_in;

   // Result register, the merge point of both lanes.
   logic             out_valid_ff, out_valid_in;
   logic signed [SW-1:0] out_left_ff, out_left_in;
   logic signed [SW-1:0] out_right_ff, out_right_in;

   logic             accept;
   logic             s1_go;
   logic             step;
   logic [AW-1:0]    wr_addr;
   logic signed [SW-1:0] left_old, right_old;
   sfd_pkg::lane_ctl_type lane_ctl;

   // Configuration writes, clamped as they are taken.
   always_comb begin
      len_eff_in  = len_eff_ff;
      gain_eff_in = gain_eff_ff;
      len_raw     = CMP_W'(csr_wdata[sfd_pkg::LEN_REG_W-1:0]);
      gain_raw    = GW'(csr_wdata[sfd_pkg::GAIN_REG_W-1:0]);
      gain_unity  = GW'(1) << GAIN_FRACTION_BITS;
      if (csr_wr_en) begin
         unique case (sfd_pkg::csr_index_type'(csr_index))
            sfd_pkg::CSR_DELAY_LENGTH: begin
               if (len_raw == '0) begin
                  len_eff_in = CMP_W'(1);
               end else if (len_raw > CMP_W'(RING_DEPTH)) begin
                  len_eff_in = CMP_W'(RING_DEPTH);
               end else begin
                  len_eff_in = len_raw;
               end
            end
            sfd_pkg::CSR_FEEDBACK_GAIN: begin
               gain_eff_in = (gain_raw > gain_unity) ? gain_unity : gain_raw;
            end
            default: begin
               len_eff_in  = len_eff_ff;
               gain_eff_in = gain_eff_ff;
            end
         endcase
      end
   end

   // Handshake and pipeline control.
   always_comb begin
      s1_go     = !out_valid_ff || rsp_ready;
      step      = s1_valid_ff && s1_go;
      req_ready = !clr_active_ff && (!s1_valid_ff || s1_go);
      accept    = req_valid && req_ready;
      // The entry written this cycle is the one being read: the RAM returns
      // the old data, so the lane must take the freshly written value.
      hit_in    = accept ? (step && (s1_addr_ff == ptr_ff)) : hit_ff;
      ptr_plus  = CMP_W'(ptr_ff) + CMP_W'(1);
      ptr_in    = ptr_ff;
      if (accept) begin
         ptr_in = (ptr_plus >= len_eff_ff) ? '0 : ptr_plus[AW-1:0];
      end
      s1_addr_in = accept ? ptr_ff : s1_addr_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (step) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   // Ring clearing pass after reset.
   always_comb begin
      clr_active_in = clr_active_ff;
      clr_cnt_in    = clr_cnt_ff;
      if (clr_active_ff) begin
         if (clr_cnt_ff == AW'(RING_DEPTH - 1)) begin
            clr_active_in = 1'b0;
         end else begin
            clr_cnt_in = clr_cnt_ff + AW'(1);
         end
      end
      wr_addr = clr_active_ff ? clr_cnt_ff : s1_addr_ff;
      lane_ctl.rd_en    = accept;
      lane_ctl.wr_en    = step;
      lane_ctl.clearing = clr_active_ff;
      lane_ctl.bypass   = hit_ff;
   end

   sfd_lane #(
      .DEPTH     (RING_DEPTH),
      .GAIN_W    (GW),
      .FRAC_BITS (GAIN_FRACTION_BITS)
   ) u_lane_left (
      .clock      (clock),
      .ctl        (lane_ctl),
      .rd_addr    (ptr_ff),
      .wr_addr    (wr_addr),
      .gain       (gain_eff_ff),
      .in_sample  (req_left_in),
      .old_sample (left_old)
   );

   sfd_lane #(
      .DEPTH     (RING_DEPTH),
      .GAIN_W    (GW),
      .FRAC_BITS (GAIN_FRACTION_BITS)
   ) u_lane_right (
      .clock      (clock),
      .ctl        (lane_ctl),
      .rd_addr    (ptr_ff),
      .wr_addr    (wr_addr),
      .gain       (gain_eff_ff),
      .in_sample  (req_right_in),
      .old_sample (right_old)
   );

   // Result stage: both lanes' delayed samples form one result word.
   always_comb begin
      out_left_in  = step ? left_old : out_left_ff;
      out_right_in = step ? right_old : out_right_ff;
      if (step) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_eff_ff    <= CMP_W'(1);
         gain_eff_ff   <= '0;
         clr_active_ff <= 1'b1;
         clr_cnt_ff    <= '0;
         ptr_ff        <= '0;
         s1_valid_ff   <= 1'b0;
         hit_ff        <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         len_eff_ff    <= len_eff_in;
         gain_eff_ff   <= gain_eff_in;
         clr_active_ff <= clr_active_in;
         clr_cnt_ff    <= clr_cnt_in;
         ptr_ff        <= ptr_in;
         s1_valid_ff   <= s1_valid_in;
         hit_ff        <= hit_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_addr_ff   <= s1_addr_in;
      out_left_ff  <= out_left_in;
      out_right_ff <= out_right_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_left_out  = out_left_ff;
   assign rsp_right_out = out_right_ff;

   // No frame may be in the update stage while the rings are being cleared.
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      clr_active_ff |-> !s1_valid_ff)
      else $error("frame in update stage during ring clearing");

   // A frame leaving the update stage always lands in the result register.
   a_step_to_out: assert property (@(posedge clock) disable iff (reset)
      step |=> out_valid_ff)
      else $error("updated frame lost before the result register");

   // The pointer never leaves the ring.
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(ptr_ff) < CMP_W'(RING_DEPTH))
      else $error("ring pointer outside the ring");

   // An accepted frame enters the update stage with the pointer it read.
   a_accept_addr: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff && (s1_addr_ff == $past(ptr_ff)))
      else $error("update stage address does not match the read pointer");

endmodule
